>>> rtl/gpq_pkg.sv
package gpq_pkg;

  localparam int COORD_W = 32;
  localparam int STEP_W  = 31;
  localparam int COUNT_W = 16;
  localparam int K_W     = COUNT_W;
  localparam int DEN_W   = STEP_W + 1;
  localparam int NUM_W   = COORD_W + 2;
  localparam int CMP_W   = DEN_W + K_W;
  localparam int CS_W    = COUNT_W + STEP_W;
  localparam int LAST_W  = CS_W + 2;
  localparam int IDX_W   = 3;

  // front stages, divider overflow stage, one stage per quotient bit, clamp, multiply, output
  localparam int LATENCY = 2 + (K_W + 1) + 3;

  typedef struct packed {
    logic below;
    logic above;
  } gpq_flags_t;

  typedef enum logic [IDX_W-1:0] {
    REG_LOWER_0 = 3'd0,
    REG_STEP_0  = 3'd1,
    REG_COUNT_0 = 3'd2,
    REG_LOWER_1 = 3'd3,
    REG_STEP_1  = 3'd4,
    REG_COUNT_1 = 3'd5
  } reg_index_t;

endpackage

>>> rtl/gpq_divider.sv
module gpq_divider (
  input  logic                      clk,
  input  logic [gpq_pkg::NUM_W-1:0] num,
  input  logic [gpq_pkg::DEN_W-1:0] den,
  input  gpq_pkg::gpq_flags_t       flags_in,
  output logic [gpq_pkg::K_W-1:0]   quot,
  output logic                      ovf,
  output gpq_pkg::gpq_flags_t       flags_out
);
  import gpq_pkg::*;

  logic [NUM_W-1:0] rem_q [0:K_W];
  logic [K_W-1:0]   quo   [0:K_W];
  logic             ovf_s [0:K_W];
  gpq_flags_t       flg   [0:K_W];

  // quotient of 2^K_W or more raises ovf
  always_ff @(posedge clk) begin
    ovf_s[0] <= CMP_W'(num) >= {den, K_W'(0)};
    rem_q[0] <= num;
    quo[0]   <= '0;
    flg[0]   <= flags_in;
  end

  for (genvar s = 1; s <= K_W; s++) begin : g_bit
    localparam int B = K_W - s;
    logic [CMP_W-1:0] shifted;
    logic [CMP_W-1:0] trial;
    logic             ge;

    assign shifted = CMP_W'(den) << B;
    assign trial   = CMP_W'(rem_q[s-1]);
    assign ge      = trial >= shifted;

    always_ff @(posedge clk) begin
      rem_q[s] <= ge ? NUM_W'(trial - shifted) : rem_q[s-1];
      quo[s]   <= {quo[s-1][K_W-2:0], ge};
      ovf_s[s] <= ovf_s[s-1];
      flg[s]   <= flg[s-1];
    end
  end

  assign quot      = quo[K_W];
  assign ovf       = ovf_s[K_W];
  assign flags_out = flg[K_W];

endmodule

>>> rtl/gpq_axis.sv
module gpq_axis (
  input  logic                               clk,
  input  logic signed [gpq_pkg::COORD_W-1:0] coord,
  input  logic signed [gpq_pkg::COORD_W-1:0] lower,
  input  logic        [gpq_pkg::STEP_W-1:0]  step,
  input  logic        [gpq_pkg::COUNT_W-1:0] count,
  output logic        [gpq_pkg::K_W-1:0]     k,
  output logic        [gpq_pkg::K_W-1:0]     k_late,
  output logic signed [gpq_pkg::COORD_W-1:0] snapped,
  output logic                               below,
  output logic                               above
);
  import gpq_pkg::*;

  logic [STEP_W-1:0]  step_eff;
  logic [COUNT_W-1:0] cnt_eff;
  logic [COUNT_W-1:0] cnt_m1;
  logic [DEN_W-1:0]   den;

  assign step_eff = (step == '0) ? STEP_W'(1) : step;
  assign cnt_eff  = (count == '0) ? COUNT_W'(1) : count;
  assign cnt_m1   = cnt_eff - COUNT_W'(1);
  assign den      = {step_eff, 1'b0};

  // stage A: offset, lower flag, span of the grid
  logic signed [COORD_W-1:0] c_a;
  logic signed [COORD_W:0]   d_a;
  logic                      below_a;
  logic [CS_W-1:0]           cs_a;

  always_ff @(posedge clk) begin
    c_a     <= coord;
    d_a     <= {coord[COORD_W-1], coord} - {lower[COORD_W-1], lower};
    below_a <= coord < lower;
    cs_a    <= CS_W'(cnt_m1) * CS_W'(step_eff);
  end

  // stage B: dividend for round half up, upper flag against the last grid point
  logic signed [LAST_W-1:0] last;
  logic signed [LAST_W-1:0] c_ext;
  logic [NUM_W-1:0]         num_b;
  gpq_flags_t               flags_b;

  assign last  = $signed({{(LAST_W-COORD_W){lower[COORD_W-1]}}, lower})
               + $signed({2'b00, cs_a});
  assign c_ext = $signed({{(LAST_W-COORD_W){c_a[COORD_W-1]}}, c_a});

  always_ff @(posedge clk) begin
    num_b         <= below_a ? '0
                   : ({1'b0, d_a[COORD_W-1:0], 1'b0} + NUM_W'(step_eff));
    flags_b.below <= below_a;
    flags_b.above <= c_ext > last;
  end

  logic [K_W-1:0] quot;
  logic           ovf;
  gpq_flags_t     flags_d;

  gpq_divider u_div (
    .clk       (clk),
    .num       (num_b),
    .den       (den),
    .flags_in  (flags_b),
    .quot      (quot),
    .ovf       (ovf),
    .flags_out (flags_d)
  );

  // clamp, then scale back to the grid
  gpq_flags_t     flags_k;
  gpq_flags_t     flags_p;
  logic [CS_W-1:0] prod;

  always_ff @(posedge clk) begin
    k       <= (ovf || (quot > cnt_m1)) ? cnt_m1 : quot;
    flags_k <= flags_d;
    prod    <= CS_W'(k) * CS_W'(step_eff);
    k_late  <= k;
    flags_p <= flags_k;
  end

  logic signed [LAST_W-1:0] sum;
  logic signed [LAST_W-1:0] max_pos;

  assign sum     = $signed({{(LAST_W-COORD_W){lower[COORD_W-1]}}, lower})
                 + $signed({2'b00, prod});
  assign max_pos = $signed({(LAST_W-COORD_W+1)'(0), {(COORD_W-1){1'b1}}});

  always_ff @(posedge clk) begin
    snapped <= (sum > max_pos) ? max_pos[COORD_W-1:0] : sum[COORD_W-1:0];
    below   <= flags_p.below;
    above   <= flags_p.above;
  end

endmodule

>>> rtl/grid_point_quantizer.sv
// channel   direction  handshake             payload
// command   in         start high, busy low  coord_0, coord_1
// result    out        strobe, one cycle     snapped_0, snapped_1, flat_index, below/above flags
// config    in         wr_en                 wr_index, wr_data
//
// One item can enter every cycle; each result passes through the front stages,
// the restoring divider (an overflow stage, then one quotient bit per stage) and
// the clamp, multiply and output stages. busy stays low.
// rst clears the valid line and loads the register reset values.
// The receiver cannot stall, so the pipeline advances on every clock.
module grid_point_quantizer (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [gpq_pkg::COORD_W-1:0] coord_0,
  input  logic signed [gpq_pkg::COORD_W-1:0] coord_1,
  output logic                               strobe,
  output logic signed [gpq_pkg::COORD_W-1:0] snapped_0,
  output logic signed [gpq_pkg::COORD_W-1:0] snapped_1,
  output logic        [gpq_pkg::COORD_W-1:0] flat_index,
  output logic                               below_0,
  output logic                               above_0,
  output logic                               below_1,
  output logic                               above_1,
  input  logic                               wr_en,
  input  logic        [gpq_pkg::IDX_W-1:0]   wr_index,
  input  logic        [gpq_pkg::COORD_W-1:0] wr_data
);
  import gpq_pkg::*;

  logic signed [COORD_W-1:0] lower_bound_0;
  logic signed [COORD_W-1:0] lower_bound_1;
  logic [STEP_W-1:0]         step_0;
  logic [STEP_W-1:0]         step_1;
  logic [COUNT_W-1:0]        point_count_0;
  logic [COUNT_W-1:0]        point_count_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lower_bound_0 <= '0;
      lower_bound_1 <= '0;
      step_0        <= STEP_W'(65536);
      step_1        <= STEP_W'(65536);
      point_count_0 <= COUNT_W'(1);
      point_count_1 <= COUNT_W'(1);
    end else if (wr_en) begin
      unique case (reg_index_t'(wr_index))
        REG_LOWER_0: lower_bound_0 <= wr_data;
        REG_STEP_0:  step_0        <= wr_data[STEP_W-1:0];
        REG_COUNT_0: point_count_0 <= wr_data[COUNT_W-1:0];
        REG_LOWER_1: lower_bound_1 <= wr_data;
        REG_STEP_1:  step_1        <= wr_data[STEP_W-1:0];
        REG_COUNT_1: point_count_1 <= wr_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic [LATENCY-1:0] vline;

  always_ff @(posedge clk) begin
    if (rst) begin
      vline <= '0;
    end else begin
      vline <= {vline[LATENCY-2:0], start && !busy};
    end
  end

  assign strobe = vline[LATENCY-1];

  logic [K_W-1:0] k0;
  logic [K_W-1:0] k0_late;
  logic [K_W-1:0] k1;
  logic [K_W-1:0] k1_late;

  gpq_axis u_axis0 (
    .clk     (clk),
    .coord   (coord_0),
    .lower   (lower_bound_0),
    .step    (step_0),
    .count   (point_count_0),
    .k       (k0),
    .k_late  (k0_late),
    .snapped (snapped_0),
    .below   (below_0),
    .above   (above_0)
  );

  gpq_axis u_axis1 (
    .clk     (clk),
    .coord   (coord_1),
    .lower   (lower_bound_1),
    .step    (step_1),
    .count   (point_count_1),
    .k       (k1),
    .k_late  (k1_late),
    .snapped (snapped_1),
    .below   (below_1),
    .above   (above_1)
  );

  logic [COUNT_W-1:0] cnt1_eff;
  logic [COORD_W-1:0] flat_prod;

  assign cnt1_eff = (point_count_1 == '0) ? COUNT_W'(1) : point_count_1;

  // row-major index; k0 and k1_late are the ones picked for alignment
  always_ff @(posedge clk) begin
    flat_prod  <= COORD_W'(k0) * COORD_W'(cnt1_eff);
    flat_index <= flat_prod + COORD_W'(k1_late);
  end

  logic unused_k0_late;
  assign unused_k0_late = ^k0_late & ^k1;

`ifndef NO_ASSERTIONS
  a_strobe_follows_item: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(start && !busy, LATENCY))
    else $error("result without a matching item");

  a_flags_0_exclusive: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(below_0 && above_0))
    else $error("axis zero below and above together");

  a_flags_1_exclusive: assert property (@(posedge clk) disable iff (rst)
    strobe |-> !(below_1 && above_1))
    else $error("axis one below and above together");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !strobe)
    else $error("result right after reset");
`endif

endmodule

>>> tb/grid_point_quantizer_test.sv
`timescale 1ns / 1ps

module grid_point_quantizer_test;
  import gpq_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef struct {
    logic [31:0] snap_0;
    logic [31:0] snap_1;
    logic [31:0] index;
    logic        lo_0;
    logic        hi_0;
    logic        lo_1;
    logic        hi_1;
  } grid_point_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [COORD_W-1:0] coord_0;
  logic signed [COORD_W-1:0] coord_1;
  logic                      strobe;
  logic signed [COORD_W-1:0] snapped_0;
  logic signed [COORD_W-1:0] snapped_1;
  logic        [COORD_W-1:0] flat_index;
  logic                      below_0;
  logic                      above_0;
  logic                      below_1;
  logic                      above_1;
  logic                      wr_en;
  logic        [IDX_W-1:0]   wr_index;
  logic        [COORD_W-1:0] wr_data;

  // shadow copy of the grid registers
  logic signed [31:0] grid_lower [2];
  logic        [30:0] grid_step  [2];
  logic        [15:0] grid_count [2];

  grid_point_t pending_points[$];
  int          mismatch_count;
  int          points_sent;
  int          points_checked;
  int          grid_settings;
  bit          quiet;

  grid_point_quantizer dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .coord_0    (coord_0),
    .coord_1    (coord_1),
    .strobe     (strobe),
    .snapped_0  (snapped_0),
    .snapped_1  (snapped_1),
    .flat_index (flat_index),
    .below_0    (below_0),
    .above_0    (above_0),
    .below_1    (below_1),
    .above_1    (above_1),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("timeout with %0d points outstanding", pending_points.size());
    $display("FAIL");
    $finish;
  end

  function automatic void snap_axis(input int ax, input logic [31:0] raw,
                                    output logic [31:0] snap, output logic lo_f,
                                    output logic hi_f, output longint k);
    longint c;
    longint lo;
    longint stp;
    longint n;
    longint last;
    longint s;
    c = longint'($signed(raw));
    lo = longint'(grid_lower[ax]);
    stp = grid_step[ax];
    n = grid_count[ax];
    if (stp == 0) stp = 1;
    if (n == 0) n = 1;
    last = lo + (n - 1) * stp;
    lo_f = c < lo;
    hi_f = c > last;
    if (c < lo) begin
      k = 0;
    end else begin
      // round half away from zero, offset is never negative here
      k = (2 * (c - lo) + stp) / (2 * stp);
      if (k > n - 1) k = n - 1;
    end
    s = lo + k * stp;
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    snap = s[31:0];
  endfunction

  function automatic grid_point_t quantize_point(input logic [31:0] c0, input logic [31:0] c1);
    grid_point_t r;
    longint      k0;
    longint      k1;
    longint      n1;
    longint      idx;
    snap_axis(0, c0, r.snap_0, r.lo_0, r.hi_0, k0);
    snap_axis(1, c1, r.snap_1, r.lo_1, r.hi_1, k1);
    n1 = grid_count[1];
    if (n1 == 0) n1 = 1;
    idx = k0 * n1 + k1;
    r.index = idx[31:0];
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s got %h expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    grid_point_t e;
    if (!rst && strobe) begin
      if (pending_points.size() == 0) begin
        report_mismatch("unexpected strobe", flat_index, '0);
      end else begin
        e = pending_points.pop_front();
        points_checked++;
        if (snapped_0 !== e.snap_0) report_mismatch("snapped_0", snapped_0, e.snap_0);
        if (snapped_1 !== e.snap_1) report_mismatch("snapped_1", snapped_1, e.snap_1);
        if (flat_index !== e.index) report_mismatch("flat_index", flat_index, e.index);
        if (below_0 !== e.lo_0)
          report_mismatch("below_0", 32'(below_0), 32'(e.lo_0));
        if (above_0 !== e.hi_0)
          report_mismatch("above_0", 32'(above_0), 32'(e.hi_0));
        if (below_1 !== e.lo_1)
          report_mismatch("below_1", 32'(below_1), 32'(e.lo_1));
        if (above_1 !== e.hi_1)
          report_mismatch("above_1", 32'(above_1), 32'(e.hi_1));
      end
    end
  end

  task automatic send_point(input logic [31:0] c0, input logic [31:0] c1);
    if (!quiet && $urandom_range(99) < 17) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1'b1;
    coord_0 <= c0;
    coord_1 <= c1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_points.push_back(quantize_point(c0, c1));
    points_sent++;
  endtask

  // hold off new items until every result is back
  task automatic drain;
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_LOWER_0: grid_lower[0] = data;
      REG_STEP_0:  grid_step[0]  = data[30:0];
      REG_COUNT_0: grid_count[0] = data[15:0];
      REG_LOWER_1: grid_lower[1] = data;
      REG_STEP_1:  grid_step[1]  = data[30:0];
      REG_COUNT_1: grid_count[1] = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(input logic [31:0] lo0, input logic [31:0] st0,
                          input logic [31:0] n0, input logic [31:0] lo1,
                          input logic [31:0] st1, input logic [31:0] n1);
    drain();
    write_reg(REG_LOWER_0, lo0);
    write_reg(REG_STEP_0, st0);
    write_reg(REG_COUNT_0, n0);
    write_reg(REG_LOWER_1, lo1);
    write_reg(REG_STEP_1, st1);
    write_reg(REG_COUNT_1, n1);
    wr_en <= 1'b0;
    grid_settings++;
  endtask

  // pick a coordinate near the grid of one axis, ties included, or at times any value
  function automatic logic [31:0] near_grid(input int ax);
    longint lo;
    longint stp;
    longint n;
    longint k;
    longint v;
    lo = longint'(grid_lower[ax]);
    stp = grid_step[ax];
    n = grid_count[ax];
    if (stp == 0) stp = 1;
    if (n == 0) n = 1;
    if ($urandom_range(99) < 20) return $urandom;
    case ($urandom_range(3))
      0: k = longint'($urandom_range(0, 2)) - 2;
      1: k = n - 2 + longint'($urandom_range(0, 3));
      default: k = longint'($urandom_range(0, 65535)) % n;
    endcase
    v = lo + k * stp;
    case ($urandom_range(5))
      0: v = v + stp / 2;
      1: v = v - stp / 2;
      2: v = v + stp / 2 + longint'($urandom_range(0, 2)) - 1;
      3: v = v + longint'($urandom % stp) - stp / 2;
      default: ;
    endcase
    return v[31:0];
  endfunction

  task automatic random_grid;
    logic [31:0] lo [2];
    logic [31:0] st [2];
    logic [31:0] n  [2];
    for (int a = 0; a < 2; a++) begin
      case ($urandom_range(2))
        0: lo[a] = $urandom;
        1: lo[a] = 32'(int'($urandom_range(0, 2000000)) - 1000000);
        default: lo[a] = 32'(int'($urandom_range(0, 200)) - 100) << 16;
      endcase
      case ($urandom_range(5))
        0: st[a] = 32'($urandom_range(0, 7));
        1: st[a] = 32'h0001_0000;
        2: st[a] = $urandom;
        3: st[a] = 32'($urandom_range(1, 32'h0010_0000));
        default: st[a] = 32'($urandom_range(1, 3)) << 14;
      endcase
      case ($urandom_range(4))
        0: n[a] = 32'($urandom_range(0, 1));
        1: n[a] = 32'h0000_FFFF;
        2: n[a] = $urandom;
        default: n[a] = 32'($urandom_range(2, 20));
      endcase
      // stray upper bits must be dropped by the register
      st[a][31] = 1'($urandom_range(1));
      n[a][31:16] = 16'($urandom);
    end
    set_grid(lo[0], st[0], n[0], lo[1], st[1], n[1]);
  endtask

  task automatic test_reset_grid;
    send_point(32'h0000_0000, 32'h0000_0000);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0000_8000, 32'hFFFF_FFFF);
  endtask

  task automatic test_directed_grids;
    // unit grid, ties half a step out both ways
    set_grid(32'h0000_0000, 32'h0001_0000, 32'd10, 32'hFFFF_0000, 32'h0001_0000, 32'd5);
    send_point(32'h0000_8000, 32'h0000_7FFF);
    send_point(32'h0001_7FFF, 32'h0001_8000);
    send_point(32'hFFFF_FFFF, 32'hFFFE_FFFF);
    send_point(32'h0009_0000, 32'h0003_0000);
    send_point(32'h0009_0001, 32'h0003_0001);
    send_point(32'h7FFF_FFFF, 32'h8000_0000);
    // widest span, largest count and step, snapped value saturates
    set_grid(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_FFFF,
             32'h7FFF_0000, 32'h7FFF_FFFF, 32'h0000_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h7FFF_0000);
    send_point(32'hFFFF_FFFF, 32'h8000_0000);
    send_point(32'h3FFF_FFFF, 32'h7FFF_8000);
    // zero step and zero count act as one; upper data bits are dropped
    set_grid(32'h0000_0010, 32'h8000_0000, 32'hFFFF_0000,
             32'hFFFF_FFF0, 32'h8000_0000, 32'h0001_0000);
    send_point(32'h0000_000F, 32'h0000_0005);
    send_point(32'h0000_0010, 32'hFFFF_FFF0);
    send_point(32'h0000_0011, 32'h8000_0000);
    // writes to unused indexes change nothing
    drain();
    write_reg(REG_SPARE_6, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_7, 32'h5555_AAAA);
    wr_en <= 1'b0;
    send_point(32'h0000_0100, 32'h0000_0100);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);
    // step one on axis zero, where every code is a grid point; step three on axis one
    set_grid(32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0100,
             32'h0000_0000, 32'h0000_0003, 32'h0000_0100);
    send_point(32'h0000_0005, 32'h0000_0004);
    send_point(32'h0000_00FE, 32'h0000_02FD);
    send_point(32'h0000_0200, 32'h0000_0001);
  endtask

  task automatic test_random_points;
    for (int phase = 0; phase < 6; phase++) begin
      random_grid();
      quiet = (phase == 3);
      repeat (90) send_point(near_grid(0), near_grid(1));
      quiet = 1'b0;
    end
  endtask

  initial begin
    start = 1'b0;
    coord_0 = '0;
    coord_1 = '0;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    rst = 1'b1;
    mismatch_count = 0;
    points_sent = 0;
    points_checked = 0;
    grid_settings = 0;
    quiet = 1'b0;
    for (int a = 0; a < 2; a++) begin
      grid_lower[a] = '0;
      grid_step[a] = 31'd65536;
      grid_count[a] = 16'd1;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_grid();
    test_directed_grids();
    test_random_points();

    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);

    $display("%0d points sent, %0d results checked, across %0d grid settings",
             points_sent, points_checked, grid_settings);
    $display("%0d mismatches", mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
